FILE: rtl/rgt_pkg.sv
// Package for the range grid triangulator: command, vertex and cell storage words,
// register indexes, function codes and vertex offset codes.
// No dependencies.
`timescale 1ns / 1ps

package rgt_pkg;

    localparam int COORD_W = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_WINDING = 2'd2;

    // function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_CELL = 1'b1;

    // vertex offset in the quad, coded {dy, dx}
    typedef logic [1:0] t_ofs;
    localparam t_ofs OFS_CORNER = 2'b00;
    localparam t_ofs OFS_RIGHT = 2'b01;
    localparam t_ofs OFS_LOWER = 2'b10;
    localparam t_ofs OFS_DIAG = 2'b11;

    typedef struct packed {
        logic                func;
        logic [COORD_W-1:0]  grid_col;
        logic [COORD_W-1:0]  grid_row;
        logic [31:0]         point_x;
        logic [31:0]         point_y;
        logic [31:0]         point_z;
        logic [15:0]         packed_color;
        logic [7:0]          quality_in;
    } t_cmd;

    typedef struct packed {
        logic [31:0]         vertex_x;
        logic [31:0]         vertex_y;
        logic [31:0]         vertex_z;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          quality;
        logic [COORD_W-1:0]  tex_u;
        logic [COORD_W-1:0]  tex_v;
        logic                last;
    } t_vertex;

    // one grid cell as held in the sample memory
    typedef struct packed {
        logic [31:0]         x;
        logic [31:0]         y;
        logic [31:0]         z;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [7:0]          quality;
    } t_cell_data;

endpackage

FILE: rtl/range_grid_triangulator_top.sv
// Range grid triangulator: per-row valid bit memory and per-cell sample memory,
// store and quad triangulation sequencer. Depends on rgt_pkg.
// Sequence: a store passes through S_SET to write its valid bit back; a cell item reads two valid map
// rows (S_VR0, S_VR1), then gives one vertex word per cycle (0, 3 or 6) from the registered sample read.
// Throughput set by the single read port of each memory; busy stays high until an item is done.
// Reset clears the valid map one row a cycle while busy is high; receiver cannot stall.
`timescale 1ns / 1ps

module range_grid_triangulator_top #(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rgt_pkg::t_cmd                 i_cmd,
    output logic                          o_strobe,
    output rgt_pkg::t_vertex              o_vertex,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rgt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rgt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(CELLS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SET   = 6'b000100,
        S_VR0   = 6'b001000,
        S_VR1   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_grid_width, r_grid_height;
    logic                  r_reverse;

    logic [RW-1:0]         r_clr_row, n_clr_row;
    logic [COORD_W-1:0]    r_col, n_col, r_row, n_row;
    logic                  r_v00, n_v00, r_v10, n_v10;
    logic [11:0]           r_seq, n_seq;
    logic [2:0]            r_cnt, n_cnt;

    logic                  r_out_vld, n_out_vld;
    logic                  r_out_last, n_out_last;
    logic [COORD_W-1:0]    r_out_u, n_out_u, r_out_v, n_out_v;

    // valid map: one row of MAX_WIDTH bits per entry
    logic [MAX_WIDTH-1:0]  vmem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]  r_vm_q;
    logic                  vm_re, vm_we;
    logic [RW-1:0]         vm_raddr, vm_waddr;
    logic [MAX_WIDTH-1:0]  vm_wdata;

    // sample memory
    t_cell_data            dmem [CELLS];
    t_cell_data            r_dm_q;
    logic                  dm_re, dm_we;
    logic [AW-1:0]         dm_raddr, dm_waddr;
    t_cell_data            dm_wdata;

    logic [CW-1:0]         col_idx, col1_idx;
    logic [MAX_WIDTH-1:0]  set_mask;
    logic [CFG_DATA_W-1:0] in_col, in_row, col_p1, row_p1;
    logic                  store_ok, cell_ok;
    logic                  v01, v11;
    logic [5:0]            tri_right, tri_lower;
    logic [COORD_W-1:0]    vtx_col, vtx_row;

    assign col_idx = CW'(r_col);
    assign col1_idx = CW'(CFG_DATA_W'(r_col) + CFG_DATA_W'(1));

    always_comb begin
        set_mask = '0;
        set_mask[col_idx] = 1'b1;
    end

    assign in_col = CFG_DATA_W'(i_cmd.grid_col);
    assign in_row = CFG_DATA_W'(i_cmd.grid_row);
    assign col_p1 = in_col + CFG_DATA_W'(1);
    assign row_p1 = in_row + CFG_DATA_W'(1);

    assign store_ok = (in_col < r_grid_width) && (in_row < r_grid_height)
                   && (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
    assign cell_ok = (col_p1 < r_grid_width) && (row_p1 < r_grid_height)
                  && (int'(col_p1) < MAX_WIDTH) && (int'(row_p1) < MAX_HEIGHT);

    assign v01 = r_vm_q[col_idx];
    assign v11 = r_vm_q[col1_idx];

    // first vertex in the low bits
    assign tri_right = r_reverse ? {OFS_RIGHT, OFS_DIAG, OFS_CORNER}
                                 : {OFS_DIAG, OFS_RIGHT, OFS_CORNER};
    assign tri_lower = r_reverse ? {OFS_DIAG, OFS_LOWER, OFS_CORNER}
                                 : {OFS_LOWER, OFS_DIAG, OFS_CORNER};

    assign vtx_col = r_col + COORD_W'(r_seq[0]);
    assign vtx_row = r_row + COORD_W'(r_seq[1]);

    always_comb begin
        n_state = r_state;
        n_clr_row = r_clr_row;
        n_col = r_col;
        n_row = r_row;
        n_v00 = r_v00;
        n_v10 = r_v10;
        n_seq = r_seq;
        n_cnt = r_cnt;
        n_out_vld = 1'b0;
        n_out_last = r_out_last;
        n_out_u = r_out_u;
        n_out_v = r_out_v;
        vm_re = 1'b0;
        vm_raddr = '0;
        vm_we = 1'b0;
        vm_waddr = '0;
        vm_wdata = '0;
        dm_re = 1'b0;
        dm_raddr = '0;
        dm_we = 1'b0;
        dm_waddr = AW'(int'(i_cmd.grid_row) * MAX_WIDTH + int'(i_cmd.grid_col));
        dm_wdata.x = i_cmd.point_x;
        dm_wdata.y = i_cmd.point_y;
        dm_wdata.z = i_cmd.point_z;
        dm_wdata.red = i_cmd.packed_color[14:10];
        dm_wdata.green = i_cmd.packed_color[9:5];
        dm_wdata.blue = i_cmd.packed_color[4:0];
        dm_wdata.quality = i_cmd.quality_in;
        case (r_state)
            S_CLEAR: begin
                vm_we = 1'b1;
                vm_waddr = r_clr_row;
                n_clr_row = r_clr_row + RW'(1);
                if (r_clr_row == RW'(MAX_HEIGHT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_col = i_cmd.grid_col;
                    n_row = i_cmd.grid_row;
                    vm_raddr = RW'(i_cmd.grid_row);
                    if (i_cmd.func == FUNC_STORE) begin
                        if (store_ok) begin
                            dm_we = 1'b1;
                            vm_re = 1'b1;
                            n_state = S_SET;
                        end
                    end else if (cell_ok) begin
                        vm_re = 1'b1;
                        n_state = S_VR0;
                    end
                end
            end
            S_SET: begin
                vm_we = 1'b1;
                vm_waddr = RW'(r_row);
                vm_wdata = r_vm_q | set_mask;
                n_state = S_IDLE;
            end
            S_VR0: begin
                n_v00 = r_vm_q[col_idx];
                n_v10 = r_vm_q[col1_idx];
                vm_re = 1'b1;
                vm_raddr = RW'(CFG_DATA_W'(r_row) + CFG_DATA_W'(1));
                n_state = S_VR1;
            end
            S_VR1: begin
                n_state = S_IDLE;
                if (r_v00 && v11 && (r_v10 || v01)) begin
                    n_state = S_EMIT;
                    n_seq = r_v10 ? {tri_lower, tri_right} : {6'b0, tri_lower};
                    n_cnt = (r_v10 && v01) ? 3'd6 : 3'd3;
                end
            end
            S_EMIT: begin
                dm_re = 1'b1;
                dm_raddr = AW'(int'(vtx_row) * MAX_WIDTH + int'(vtx_col));
                n_out_vld = 1'b1;
                n_out_u = vtx_col;
                n_out_v = vtx_row;
                n_out_last = (r_cnt == 3'd1);
                n_seq = r_seq >> 2;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_row <= '0;
            r_out_vld <= 1'b0;
            r_grid_width <= CFG_DATA_W'(512);
            r_grid_height <= CFG_DATA_W'(512);
            r_reverse <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr_row <= n_clr_row;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH: begin
                        r_grid_width <= i_cfg_data;
                    end
                    CFG_GRID_HEIGHT: begin
                        r_grid_height <= i_cfg_data;
                    end
                    CFG_REVERSE_WINDING: begin
                        r_reverse <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_row <= n_row;
        r_v00 <= n_v00;
        r_v10 <= n_v10;
        r_seq <= n_seq;
        r_cnt <= n_cnt;
        r_out_last <= n_out_last;
        r_out_u <= n_out_u;
        r_out_v <= n_out_v;
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            vmem[vm_waddr] <= vm_wdata;
        end
        if (vm_re) begin
            r_vm_q <= vmem[vm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if (dm_re) begin
            r_dm_q <= dmem[dm_raddr];
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe = r_out_vld;

    assign o_vertex.vertex_x = r_dm_q.x;
    assign o_vertex.vertex_y = r_dm_q.y;
    assign o_vertex.vertex_z = r_dm_q.z;
    assign o_vertex.red = {r_dm_q.red, 3'b000};
    assign o_vertex.green = {r_dm_q.green, 3'b000};
    assign o_vertex.blue = {r_dm_q.blue, 3'b000};
    assign o_vertex.quality = r_dm_q.quality;
    assign o_vertex.tex_u = r_out_u;
    assign o_vertex.tex_v = r_out_v;
    assign o_vertex.last = r_out_last;

    // vertex words only come out of the emit sequence
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("vertex word without emit");

    // the closing vertex ends the burst
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_vertex.last) |=> !o_strobe)
        else $error("vertex word after last");

    // a store never produces a vertex word
    a_store_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_STORE) |=> !o_strobe)
        else $error("vertex word after store");

    // the clearing pass keeps busy high, writes the valid map and gives no vertex word
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (busy && !o_strobe && vm_we))
        else $error("clearing pass not exclusive");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_grid_triangulator_top: stores scanner samples into the grid,
// triangulates cells and checks each vertex word against a local grid model.
// Depends on rgt_pkg and range_grid_triangulator_top.

module tb_top;
    import rgt_pkg::*;

    localparam int GRID_W_MAX = 512;
    localparam int GRID_H_MAX = 512;
    localparam int GRID_CELLS = GRID_W_MAX * GRID_H_MAX;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  quality;
    } t_point_rec;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_cmd                  cmd_word = '0;
    logic                  vtx_strobe;
    t_vertex               vtx_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // grid model
    bit         cell_valid [GRID_CELLS];
    t_point_rec point_mem [GRID_CELLS];
    int         cfg_grid_w = 512;
    int         cfg_grid_h = 512;
    bit         cfg_reverse = 1'b0;
    t_vertex    expected_vertices [$];

    int send_idle_pct = 0;
    int n_mismatch = 0;
    int cycle_count = 0;

    range_grid_triangulator_top #(
        .MAX_WIDTH(GRID_W_MAX),
        .MAX_HEIGHT(GRID_H_MAX)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(cmd_word),
        .o_strobe(vtx_strobe),
        .o_vertex(vtx_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int eff_width();
        return (cfg_grid_w < GRID_W_MAX) ? cfg_grid_w : GRID_W_MAX;
    endfunction

    function automatic int eff_height();
        return (cfg_grid_h < GRID_H_MAX) ? cfg_grid_h : GRID_H_MAX;
    endfunction

    function automatic int cell_addr(input int c, input int r);
        return r * GRID_W_MAX + c;
    endfunction

    function automatic t_vertex vertex_at(input int c, input int r);
        t_point_rec p;
        t_vertex    v;
        p = point_mem[cell_addr(c, r)];
        v.vertex_x = p.x;
        v.vertex_y = p.y;
        v.vertex_z = p.z;
        v.red = p.red;
        v.green = p.green;
        v.blue = p.blue;
        v.quality = p.quality;
        v.tex_u = 9'(c);
        v.tex_v = 9'(r);
        v.last = 1'b0;
        return v;
    endfunction

    // updates the grid model and queues the vertex words a command gives
    function automatic void predict_grid_item(input t_cmd cmd);
        int         c;
        int         r;
        int         w;
        int         h;
        t_point_rec p;
        t_vertex    tri_q [$];
        c = int'(cmd.grid_col);
        r = int'(cmd.grid_row);
        w = eff_width();
        h = eff_height();
        if (cmd.func == FUNC_STORE) begin
            if (c < w && r < h) begin
                p.x = cmd.point_x;
                p.y = cmd.point_y;
                p.z = cmd.point_z;
                p.red = {cmd.packed_color[14:10], 3'b000};
                p.green = {cmd.packed_color[9:5], 3'b000};
                p.blue = {cmd.packed_color[4:0], 3'b000};
                p.quality = cmd.quality_in;
                point_mem[cell_addr(c, r)] = p;
                cell_valid[cell_addr(c, r)] = 1'b1;
            end
            return;
        end
        if (c + 1 >= w || r + 1 >= h)
            return;
        if (!cell_valid[cell_addr(c, r)] || !cell_valid[cell_addr(c + 1, r + 1)])
            return;
        if (cell_valid[cell_addr(c + 1, r)]) begin
            tri_q.push_back(vertex_at(c, r));
            if (cfg_reverse) begin
                tri_q.push_back(vertex_at(c + 1, r + 1));
                tri_q.push_back(vertex_at(c + 1, r));
            end else begin
                tri_q.push_back(vertex_at(c + 1, r));
                tri_q.push_back(vertex_at(c + 1, r + 1));
            end
        end
        if (cell_valid[cell_addr(c, r + 1)]) begin
            tri_q.push_back(vertex_at(c, r));
            if (cfg_reverse) begin
                tri_q.push_back(vertex_at(c, r + 1));
                tri_q.push_back(vertex_at(c + 1, r + 1));
            end else begin
                tri_q.push_back(vertex_at(c + 1, r + 1));
                tri_q.push_back(vertex_at(c, r + 1));
            end
        end
        if (tri_q.size() != 0)
            tri_q[tri_q.size() - 1].last = 1'b1;
        foreach (tri_q[i])
            expected_vertices.push_back(tri_q[i]);
    endfunction

    function automatic t_cmd make_cmd(input logic func, input int c, input int r,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [15:0] color,
                                      input logic [7:0] q);
        t_cmd cmd;
        cmd.func = func;
        cmd.grid_col = 9'(c);
        cmd.grid_row = 9'(r);
        cmd.point_x = x;
        cmd.point_y = y;
        cmd.point_z = z;
        cmd.packed_color = color;
        cmd.quality_in = q;
        return cmd;
    endfunction

    function automatic t_cmd random_cmd(input logic func, input int c, input int r);
        return make_cmd(func, c, r, $urandom, $urandom, $urandom,
                        16'($urandom_range(65535)), 8'($urandom_range(255)));
    endfunction

    // start stays high after acceptance; it is lowered by a gap or a drain
    task automatic send_item(input t_cmd cmd);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd_word <= cmd;
        do @(posedge clk); while (busy);
        predict_grid_item(cmd);
    endtask

    task automatic store_point(input int c, input int r, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z,
                               input logic [15:0] color, input logic [7:0] q);
        send_item(make_cmd(FUNC_STORE, c, r, x, y, z, color, q));
    endtask

    task automatic cell_item(input int c, input int r);
        send_item(random_cmd(FUNC_CELL, c, r));
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_GRID_WIDTH: cfg_grid_w = int'(value);
            CFG_GRID_HEIGHT: cfg_grid_h = int'(value);
            CFG_REVERSE_WINDING: cfg_reverse = value[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // full quads at both grid corners, field extremes
    task automatic test_full_quads();
        send_idle_pct = 0;
        store_point(0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF, 8'hFF);
        store_point(1, 0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7F80_0000, 16'h0000, 8'h00);
        store_point(1, 1, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_0001, 16'h7C00, 8'h55);
        store_point(0, 1, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 16'h03E0, 8'hAA);
        cell_item(0, 0);
        store_point(510, 510, $urandom, $urandom, $urandom, 16'h001F, 8'h01);
        store_point(511, 510, $urandom, $urandom, $urandom, 16'h8000, 8'h80);
        store_point(511, 511, $urandom, $urandom, $urandom, 16'h5555, 8'h7F);
        store_point(510, 511, $urandom, $urandom, $urandom, 16'hAAAA, 8'hFE);
        cell_item(510, 510);
        cell_item(511, 510);
        cell_item(510, 511);
    endtask

    // one triangle or none
    task automatic test_partial_quads();
        send_idle_pct = 0;
        store_point(100, 100, $urandom, $urandom, $urandom, 16'h1234, 8'h11);
        store_point(101, 101, $urandom, $urandom, $urandom, 16'h4321, 8'h22);
        store_point(101, 100, $urandom, $urandom, $urandom, 16'h0F0F, 8'h33);
        cell_item(100, 100);
        store_point(200, 200, $urandom, $urandom, $urandom, 16'hF0F0, 8'h44);
        store_point(201, 201, $urandom, $urandom, $urandom, 16'h3C3C, 8'h66);
        store_point(200, 201, $urandom, $urandom, $urandom, 16'hC3C3, 8'h77);
        cell_item(200, 200);
        store_point(300, 300, $urandom, $urandom, $urandom, 16'h6666, 8'h88);
        store_point(301, 301, $urandom, $urandom, $urandom, 16'h9999, 8'h99);
        cell_item(300, 300);
        cell_item(0, 1);
        cell_item(99, 99);
    endtask

    task automatic test_winding();
        wait_drain();
        write_cfg(CFG_REVERSE_WINDING, 10'd1);
        cell_item(0, 0);
        wait_drain();
        write_cfg(CFG_REVERSE_WINDING, 10'd0);
    endtask

    task automatic test_grid_limits();
        wait_drain();
        write_cfg(CFG_GRID_WIDTH, 10'd2);
        write_cfg(CFG_GRID_HEIGHT, 10'd2);
        store_point(2, 0, $urandom, $urandom, $urandom, 16'hFFFF, 8'hFF);
        store_point(0, 2, $urandom, $urandom, $urandom, 16'hFFFF, 8'hFF);
        cell_item(0, 0);
        cell_item(1, 0);
        wait_drain();
        write_cfg(CFG_GRID_WIDTH, 10'd0);
        store_point(0, 0, $urandom, $urandom, $urandom, 16'h7FFF, 8'h5A);
        wait_drain();
        write_cfg(CFG_GRID_WIDTH, 10'd1023);
        write_cfg(CFG_GRID_HEIGHT, 10'd1023);
        write_cfg(CFG_UNUSED, 10'h3FF);
        store_point(511, 511, $urandom, $urandom, $urandom, 16'h2AD5, 8'hC3);
        cell_item(510, 510);
        wait_drain();
        write_cfg(CFG_GRID_WIDTH, 10'd1);
        write_cfg(CFG_GRID_HEIGHT, 10'd1);
        store_point(0, 0, $urandom, $urandom, $urandom, 16'h1111, 8'h3C);
        cell_item(0, 0);
        wait_drain();
        write_cfg(CFG_GRID_WIDTH, 10'd512);
        write_cfg(CFG_GRID_HEIGHT, 10'd512);
        cell_item(0, 0);
    endtask

    // mostly quad fills followed by a cell word, some random words
    task automatic test_random_phase(input int idle_pct, input int w, input int h,
                                     input bit reverse, input int n_items);
        int sent;
        int c0;
        int r0;
        int c;
        int r;
        bit paused;
        wait_drain();
        write_cfg(CFG_GRID_WIDTH, 10'(w));
        write_cfg(CFG_GRID_HEIGHT, 10'(h));
        write_cfg(CFG_REVERSE_WINDING, 10'(reverse));
        send_idle_pct = idle_pct;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                wait_drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 75) begin
                c0 = $urandom_range(eff_width() - 1);
                r0 = $urandom_range(eff_height() - 1);
                for (int k = 0; k < 4; k++) begin
                    c = c0 + k % 2;
                    r = r0 + k / 2;
                    if (c < GRID_W_MAX && r < GRID_H_MAX && $urandom_range(3) != 0) begin
                        send_item(random_cmd(FUNC_STORE, c, r));
                        sent++;
                    end
                end
                send_item(random_cmd(FUNC_CELL, c0, r0));
            end else begin
                send_item(random_cmd(1'($urandom_range(1)), $urandom_range(511),
                                     $urandom_range(511)));
            end
            sent++;
        end
    endtask

    always @(posedge clk) begin
        t_vertex want;
        if (vtx_strobe === 1'b1) begin
            if (expected_vertices.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: unexpected vertex word %h", $time, vtx_word);
            end else begin
                want = expected_vertices.pop_front();
                if (vtx_word.vertex_x !== want.vertex_x || vtx_word.vertex_y !== want.vertex_y ||
                    vtx_word.vertex_z !== want.vertex_z || vtx_word.red !== want.red ||
                    vtx_word.green !== want.green || vtx_word.blue !== want.blue ||
                    vtx_word.quality !== want.quality || vtx_word.tex_u !== want.tex_u ||
                    vtx_word.tex_v !== want.tex_v || vtx_word.last !== want.last) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS) begin
                        $display("%0t: vertex mismatch", $time);
                        $display("  want x=%h y=%h z=%h rgb=%h,%h,%h q=%h uv=%0d,%0d last=%b",
                                 want.vertex_x, want.vertex_y, want.vertex_z, want.red,
                                 want.green, want.blue, want.quality, want.tex_u,
                                 want.tex_v, want.last);
                        $display("  got  x=%h y=%h z=%h rgb=%h,%h,%h q=%h uv=%0d,%0d last=%b",
                                 vtx_word.vertex_x, vtx_word.vertex_y, vtx_word.vertex_z,
                                 vtx_word.red, vtx_word.green, vtx_word.blue,
                                 vtx_word.quality, vtx_word.tex_u, vtx_word.tex_v,
                                 vtx_word.last);
                    end
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        test_full_quads();
        test_partial_quads();
        test_winding();
        test_grid_limits();
        test_random_phase(8, 512, 512, 1'b0, 32);
        test_random_phase(61, $urandom_range(2, 48), $urandom_range(2, 48), 1'b1, 31);
        test_random_phase(0, 1023, $urandom_range(256, 512), 1'($urandom_range(1)), 31);
        wait_drain();
        if (n_mismatch == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
